@@ rtl/rle_decoder_with_alpha_insert_macros.svh @@
// Assertion macros shared by the run-length decoder modules.
`ifndef RLE_DECODER_WITH_ALPHA_INSERT_MACROS_SVH
`define RLE_DECODER_WITH_ALPHA_INSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RLD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rld check failed");
`define RLD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rld check failed");
`else
`define RLD_ASSERT_IMP(lbl, ante, cons)
`define RLD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/rld_pkg.sv @@
// Shared types and constants of the run-length decoder.
package rld_pkg;
	localparam logic [7:0] CTRL_ZERO = 8'h00;
	localparam logic [7:0] CTRL_LIT = 8'hFF;
	localparam logic [7:0] ALPHA_ZERO = 8'h00;
	localparam logic [7:0] ALPHA_LIT = 8'hFF;
	localparam logic [1:0] ALPHA_GROUP = 2'd3;
	// floor(s/3) = (s*171) >> 9 for every s below 258
	localparam logic [16:0] DIV3_MUL = 17'd171;
	localparam int DIV3_SHIFT = 9;
	localparam int MAX_RES = 3;
	localparam logic [0:0] REG_ALPHA_MODE = 1'b0;

	typedef struct packed {
		logic [7:0] byte_in;
		logic end_of_stream;
	} in_t;

	typedef struct packed {
		logic [7:0] value;
		logic [8:0] repeat_count;
		logic is_alpha;
		logic truncated;
		logic last_result;
	} out_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_t [MAX_RES-1:0] res;
	} batch_t;
endpackage

@@ rtl/rld_regs.sv @@
// APB configuration register holding the alpha mode bit.
module rld_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        alpha_mode
);
	logic alpha_q;

	assign pready = 1'b1;
	assign alpha_mode = alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == rld_pkg::REG_ALPHA_MODE) begin
			alpha_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rld_pkg::REG_ALPHA_MODE) begin
			prdata[0] = alpha_q;
		end
	end
endmodule

@@ rtl/rld_core.sv @@
// Input register, decoder state and per-byte result decode.
module rld_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            alpha_mode,
	input  logic            in_valid,
	output logic            in_ready,
	input  rld_pkg::in_t    in_data,
	input  logic            can_load,
	output logic            load,
	output rld_pkg::batch_t batch
);
	`include "rle_decoder_with_alpha_insert_macros.svh"

	typedef enum logic [1:0] {
		PH_CONTROL,
		PH_COUNT,
		PH_SINGLE,
		PH_LITERAL
	} phase_t;

	logic         valid_s1;
	rld_pkg::in_t data_s1;
	phase_t       phase_q, phase_d;
	logic [7:0]   lit_q, lit_d;
	logic [1:0]   ch_q, ch_d;
	logic [7:0]   held_q, held_d;

	logic [8:0]   run_sum;
	logic [16:0]  run_prod;
	logic [7:0]   run_quo;
	logic [8:0]   run_rem;
	logic [2:0]   ch_inc;
	logic         any_trunc;

	assign load = valid_s1 && can_load;
	assign in_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CONTROL;
			lit_q   <= '0;
			ch_q    <= '0;
			held_q  <= '0;
		end else if (load) begin
			phase_q <= phase_d;
			lit_q   <= lit_d;
			ch_q    <= ch_d;
			held_q  <= held_d;
		end
	end

	// zero run with alpha: total = b + (ch+b)/3, new channel = (ch+b)%3
	assign run_sum  = {1'b0, data_s1.byte_in} + {7'b0, ch_q};
	assign run_prod = 17'(run_sum) * rld_pkg::DIV3_MUL;
	assign run_quo  = run_prod[rld_pkg::DIV3_SHIFT +: 8];
	assign run_rem  = run_sum - 9'(run_quo) * 9'd3;
	assign ch_inc   = {1'b0, ch_q} + 3'd1;

	always_comb begin
		phase_d = phase_q;
		lit_d   = lit_q;
		ch_d    = ch_q;
		held_d  = held_q;
		batch   = '0;
		unique case (phase_q)
			PH_CONTROL: begin
				held_d = data_s1.byte_in;
				phase_d = (data_s1.byte_in == rld_pkg::CTRL_ZERO
					|| data_s1.byte_in == rld_pkg::CTRL_LIT) ? PH_COUNT : PH_SINGLE;
			end
			PH_COUNT: begin
				if (held_q == rld_pkg::CTRL_ZERO) begin
					if (data_s1.byte_in != 8'd0) begin
						batch.res[0].value = 8'd0;
						batch.res[0].repeat_count = {1'b0, data_s1.byte_in};
						if (alpha_mode) begin
							batch.res[0].repeat_count = {1'b0, data_s1.byte_in}
								+ {1'b0, run_quo};
							ch_d = run_rem[1:0];
						end
						batch.cnt = 2'd1;
					end
					phase_d = PH_CONTROL;
				end else begin
					lit_d = data_s1.byte_in;
					phase_d = (data_s1.byte_in != 8'd0) ? PH_LITERAL : PH_CONTROL;
				end
			end
			PH_SINGLE, PH_LITERAL: begin
				batch.res[0].value = data_s1.byte_in;
				batch.res[0].repeat_count = 9'd1;
				batch.cnt = 2'd1;
				if (alpha_mode) begin
					if (ch_inc[1:0] == rld_pkg::ALPHA_GROUP) begin
						batch.res[1].value = (phase_q == PH_SINGLE) ? held_q
							: rld_pkg::ALPHA_LIT;
						batch.res[1].repeat_count = 9'd1;
						batch.res[1].is_alpha = 1'b1;
						batch.cnt = 2'd2;
						ch_d = 2'd0;
					end else begin
						ch_d = ch_inc[1:0];
					end
				end
				if (phase_q == PH_SINGLE) begin
					phase_d = PH_CONTROL;
				end else begin
					lit_d = lit_q - 8'd1;
					if (lit_d == 8'd0) begin
						phase_d = PH_CONTROL;
					end
				end
			end
			default: begin
				phase_d = PH_CONTROL;
			end
		endcase

		if (data_s1.end_of_stream) begin
			if (phase_d != PH_CONTROL) begin
				batch.res[batch.cnt].truncated = 1'b1;
				batch.cnt = batch.cnt + 2'd1;
			end
			phase_d = PH_CONTROL;
			lit_d = '0;
			ch_d = '0;
		end

		if (batch.cnt != 2'd0) begin
			batch.res[batch.cnt - 2'd1].last_result = 1'b1;
		end
	end

	assign any_trunc = batch.res[0].truncated || batch.res[1].truncated
		|| batch.res[2].truncated;

	`RLD_ASSERT_IMP(a_trunc_only_at_eos, load && any_trunc, data_s1.end_of_stream)
	`RLD_ASSERT_NXT(a_eos_clears_state, load && data_s1.end_of_stream,
		phase_q == PH_CONTROL && lit_q == 8'd0 && ch_q == 2'd0)
	`RLD_ASSERT_IMP(a_channel_range, 1'b1, ch_q != 2'd3)
	`RLD_ASSERT_IMP(a_literal_run_count, phase_q == PH_LITERAL, lit_q != 8'd0)
endmodule

@@ rtl/rld_outbuf.sv @@
// Result buffer that hands out one decoded result per beat.
module rld_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  rld_pkg::batch_t batch,
	output logic            can_load,
	output logic            out_valid,
	input  logic            out_ready,
	output rld_pkg::out_t   out_data
);
	`include "rle_decoder_with_alpha_insert_macros.svh"

	rld_pkg::out_t rb_q [rld_pkg::MAX_RES];
	logic [1:0]    count_q;
	logic          pop;

	assign out_valid = count_q != 2'd0;
	assign out_data  = rb_q[0];
	assign pop       = out_valid && out_ready;
	assign can_load  = (count_q == 2'd0) || (count_q == 2'd1 && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= batch.cnt;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// slot 0 always holds the oldest result
	always_ff @(posedge clk) begin
		if (load) begin
			rb_q[0] <= batch.res[0];
			rb_q[1] <= batch.res[1];
			rb_q[2] <= batch.res[2];
		end else if (pop) begin
			rb_q[0] <= rb_q[1];
			rb_q[1] <= rb_q[2];
		end
	end

	`RLD_ASSERT_IMP(a_load_needs_room, load, count_q == 2'd0 || (count_q == 2'd1 && pop))
	`RLD_ASSERT_NXT(a_hold_when_stalled, out_valid && !out_ready,
		count_q == $past(count_q))
	`RLD_ASSERT_NXT(a_pop_advances, pop && !load, count_q == $past(count_q) - 2'd1)
endmodule

@@ rtl/rle_decoder_with_alpha_insert.sv @@
// Top level of the run-length decoder with alpha insertion.
// Takes one compressed byte per beat and returns decoded results one per beat: a zero run
// as a single result with a repeat count, colour bytes, inserted alpha bytes (alpha mode,
// register 0 at address 0) and a truncated marker when the stream ends inside a construct.
// A byte is registered, decoded combinationally and its results loaded into a three-entry
// result buffer; the next byte is loaded only once the single result port has drained the
// buffer down to its last result, which leaves in the same cycle, or emptied it.
module rle_decoder_with_alpha_insert (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          in_valid,
	output logic          in_ready,
	input  rld_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rld_pkg::out_t out_data
);
	logic            alpha_mode;
	logic            can_load;
	logic            load;
	rld_pkg::batch_t batch;

	rld_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.alpha_mode (alpha_mode)
	);

	rld_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.alpha_mode (alpha_mode),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.can_load   (can_load),
		.load       (load),
		.batch      (batch)
	);

	rld_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.batch     (batch),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule

@@ dv/rle_decoder_with_alpha_insert_tb.sv @@
// Self-checking testbench of the run-length decoder: directed streams, random streams, stalls.
module rle_decoder_with_alpha_insert_tb;
	localparam int LATENCY_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int STALL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 96;
	localparam int PRESSURE_ITEMS = 24;
	localparam logic [2:0] ADDR_ALPHA_MODE = 3'(4 * rld_pkg::REG_ALPHA_MODE);

	typedef enum logic [1:0] {
		AWAIT_CTRL,
		AWAIT_COUNT,
		AWAIT_SINGLE,
		IN_LITERAL
	} dec_phase_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;
	logic          in_valid = 1'b0;
	logic          in_ready;
	rld_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	rld_pkg::out_t out_data;

	// decoder state mirrored by the predictor
	dec_phase_t  dec_phase = AWAIT_CTRL;
	logic [7:0]  lits_left = '0;
	int          chan_idx = 0;
	logic [7:0]  ctrl_held = '0;
	logic        alpha_on = 1'b0;

	rld_pkg::out_t step_results[$];
	rld_pkg::out_t pending_results[$];

	int err_count = 0;
	int n_results = 0;
	int items_sent = 0;
	int tx_idle_pct = 24;
	int rx_idle_pct = 69;
	int stall_asks = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	rle_decoder_with_alpha_insert u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function void emit(logic [7:0] v, logic [8:0] rep, logic alpha, logic trunc);
		rld_pkg::out_t r;
		r.value = v;
		r.repeat_count = rep;
		r.is_alpha = alpha;
		r.truncated = trunc;
		r.last_result = 1'b0;
		step_results.push_back(r);
	endfunction

	function void emit_colour(logic [7:0] v, logic [7:0] alpha_val);
		emit(v, 9'd1, 1'b0, 1'b0);
		if (alpha_on) begin
			chan_idx++;
			if (chan_idx >= rld_pkg::ALPHA_GROUP) begin
				emit(alpha_val, 9'd1, 1'b1, 1'b0);
				chan_idx = 0;
			end
		end
	endfunction

	// Work out the results of one accepted byte and queue them.
	function void decode_byte(rld_pkg::in_t item);
		int s;
		int total;
		step_results.delete();
		case (dec_phase)
			AWAIT_CTRL: begin
				ctrl_held = item.byte_in;
				dec_phase = (item.byte_in == rld_pkg::CTRL_ZERO
					|| item.byte_in == rld_pkg::CTRL_LIT) ? AWAIT_COUNT : AWAIT_SINGLE;
			end
			AWAIT_COUNT: begin
				if (ctrl_held == rld_pkg::CTRL_ZERO) begin
					if (item.byte_in != 0) begin
						total = item.byte_in;
						if (alpha_on) begin
							s = chan_idx + item.byte_in;
							total = item.byte_in + s / 3;
							chan_idx = s % 3;
						end
						emit('0, 9'(total), 1'b0, 1'b0);
					end
					dec_phase = AWAIT_CTRL;
				end else begin
					lits_left = item.byte_in;
					dec_phase = (item.byte_in != 0) ? IN_LITERAL : AWAIT_CTRL;
				end
			end
			AWAIT_SINGLE: begin
				emit_colour(item.byte_in, ctrl_held);
				dec_phase = AWAIT_CTRL;
			end
			default: begin
				emit_colour(item.byte_in, rld_pkg::ALPHA_LIT);
				lits_left = lits_left - 8'd1;
				if (lits_left == 0)
					dec_phase = AWAIT_CTRL;
			end
		endcase
		if (item.end_of_stream) begin
			if (dec_phase != AWAIT_CTRL)
				emit('0, 9'd0, 1'b0, 1'b1);
			dec_phase = AWAIT_CTRL;
			lits_left = '0;
			chan_idx = 0;
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last_result = 1'b1;
		foreach (step_results[i])
			pending_results.push_back(step_results[i]);
	endfunction

	task report_mismatch(string msg);
		$display("ERROR: %s", msg);
		err_count++;
	endtask

	task check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("result %0d: %s is %0d, want %0d",
				n_results, name, got, want));
	endtask

	always @(posedge clk) begin : result_check
		rld_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected", n_results));
			end else begin
				want = pending_results.pop_front();
				check_field("value", out_data.value, want.value);
				check_field("repeat_count", out_data.repeat_count, want.repeat_count);
				check_field("is_alpha", out_data.is_alpha, want.is_alpha);
				check_field("truncated", out_data.truncated, want.truncated);
				check_field("last_result", out_data.last_result, want.last_result);
			end
			n_results++;
		end
	end

	// Hold off for a long stretch when asked, else idle at random.
	always @(posedge clk) begin
		if (stall_asks != stall_seen) begin
			stall_seen = stall_asks;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task send_byte(rld_pkg::in_t item);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
		decode_byte(item);
		items_sent++;
	endtask

	task send_seq(logic [7:0] bytes[$], bit eos_last);
		rld_pkg::in_t item;
		foreach (bytes[i]) begin
			item.byte_in = bytes[i];
			item.end_of_stream = eos_last && (i == bytes.size() - 1);
			send_byte(item);
		end
	endtask

	// Drop valid, let all results drain, then let the pipeline settle.
	task wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	task apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ALPHA_MODE)
			alpha_on = data[0];
	endtask

	task send_random_construct(bit broken);
		rld_pkg::in_t seq[$];
		rld_pkg::in_t item;
		int kind;
		int count;
		int cut;
		kind = $urandom_range(2);
		item.end_of_stream = 1'b0;
		case (kind)
			0: begin
				item.byte_in = rld_pkg::CTRL_ZERO;
				seq.push_back(item);
				item.byte_in = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
				seq.push_back(item);
			end
			1: begin
				count = ($urandom_range(15) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
				item.byte_in = rld_pkg::CTRL_LIT;
				seq.push_back(item);
				item.byte_in = 8'(count);
				seq.push_back(item);
				repeat (count) begin
					item.byte_in = 8'($urandom_range(255));
					seq.push_back(item);
				end
			end
			default: begin
				item.byte_in = 8'($urandom_range(254, 1));
				seq.push_back(item);
				item.byte_in = 8'($urandom_range(255));
				seq.push_back(item);
			end
		endcase
		if (broken) begin
			// end the stream early, inside the construct
			cut = $urandom_range(seq.size() - 2);
			seq[cut].end_of_stream = 1'b1;
			seq = seq[0:cut];
		end else if ($urandom_range(3) == 0) begin
			seq[seq.size() - 1].end_of_stream = 1'b1;
		end
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task test_plain_directed();
		wait_idle();
		apb_write(ADDR_ALPHA_MODE, 32'hFFFF_FFFE);
		send_seq('{rld_pkg::CTRL_ZERO, 8'h00}, 1'b0);
		send_seq('{rld_pkg::CTRL_ZERO, 8'hFF}, 1'b0);
		send_seq('{rld_pkg::CTRL_LIT, 8'h00}, 1'b0);
		send_seq('{rld_pkg::CTRL_LIT, 8'h02, 8'h00, 8'hFF}, 1'b0);
		send_seq('{8'hFE, 8'h7F}, 1'b1);
		send_seq('{8'h55}, 1'b1);
		send_seq('{rld_pkg::CTRL_LIT, 8'h03, 8'hAA}, 1'b1);
		// leave a literal run open across the mode change
		send_seq('{rld_pkg::CTRL_LIT, 8'h04, 8'h12, 8'h34}, 1'b0);
	endtask

	task test_alpha_directed();
		wait_idle();
		apb_write(ADDR_ALPHA_MODE, 32'h0000_0001);
		send_seq('{8'h56, 8'h78}, 1'b0);
		// channel sits at two here, so this run carries the largest count
		send_seq('{rld_pkg::CTRL_ZERO, 8'hFF}, 1'b0);
		send_seq('{8'h01, 8'h02}, 1'b0);
		send_seq('{rld_pkg::CTRL_LIT, 8'h00}, 1'b1);
		send_seq('{rld_pkg::CTRL_LIT, 8'h03, 8'h11, 8'h22, 8'h33}, 1'b0);
	endtask

	task test_random_streams();
		int mode;
		int target;
		int r;
		rld_pkg::in_t item;
		for (mode = 0; mode < 3; mode++) begin
			wait_idle();
			tx_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 69 : 0;
			rx_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 24 : 0;
			apb_write(ADDR_ALPHA_MODE, (mode == 2) ? $urandom_range(1) : 32'(mode));
			target = items_sent + RANDOM_ITEMS / 3;
			while (items_sent < target) begin
				r = $urandom_range(9);
				if (r < 7) begin
					send_random_construct(1'b0);
				end else if (r == 7) begin
					send_random_construct(1'b1);
				end else begin
					item.byte_in = 8'($urandom_range(255));
					item.end_of_stream = ($urandom_range(9) == 0);
					send_byte(item);
				end
			end
		end
	endtask

	task test_output_backpressure();
		int target;
		wait_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apb_write(ADDR_ALPHA_MODE, 32'h0000_0001);
		stall_asks++;
		target = items_sent + PRESSURE_ITEMS;
		while (items_sent < target)
			send_random_construct(1'b0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_directed();
		test_alpha_directed();
		test_random_streams();
		test_output_backpressure();
		wait_idle();
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
